[rtl/rth_pkg.sv]
// Shared types, constants and defaults for the regional triple histogram.
package rth_pkg;

  // Default sizing of the counter banks
  localparam int DEF_MAX_BINS    = 128;
  localparam int DEF_MAX_REGIONS = 64;
  localparam int DEF_COUNT_BITS  = 32;

  // Fixed field widths
  localparam int OUT_BITS    = 32;
  localparam int VALUE_BITS  = 24;
  localparam int SUM_BITS    = VALUE_BITS + 1;
  localparam int LIMIT_BITS  = 23;
  localparam int BCOUNT_BITS = 8;
  localparam int SCALE_BITS  = 32;
  localparam int REGION_BITS = 6;
  localparam int RBIN_BITS   = 7;
  localparam int SEL_BITS    = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int LANES       = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_COUNT   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_SCALE   = 2'd2;

  // Register reset values
  localparam logic [LIMIT_BITS-1:0]  RST_RANGE_LIMIT = 23'd65536;
  localparam logic [BCOUNT_BITS-1:0] RST_BIN_COUNT   = 8'd128;
  localparam logic [SCALE_BITS-1:0]  RST_BIN_SCALE   = 32'd4194304;

  // Item actions
  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Histogram selectors
  localparam logic [SEL_BITS-1:0] HIST_FIRST  = 2'd0;
  localparam logic [SEL_BITS-1:0] HIST_SECOND = 2'd1;
  localparam logic [SEL_BITS-1:0] HIST_THIRD  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_READ,
    ST_DONE
  } rth_state_t;

  // Per-step strobes from the sequencer to each lane
  typedef struct packed {
    logic clear_en;
    logic mul_en;
    logic rd_en;
    logic wr_en;
    logic use_read_bin;
  } rth_ctrl_t;

endpackage

[rtl/rth_lane.sv]
// One histogram lane: bins one value and keeps its bank of saturating counters.
module rth_lane import rth_pkg::*; #(
  parameter int MAX_BINS    = DEF_MAX_BINS,
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  localparam int DEPTH  = MAX_BINS * MAX_REGIONS,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int BIN_W  = $clog2(MAX_BINS)
) (
  input  logic                        clk,
  input  rth_ctrl_t                   ctrl,
  input  logic [ADDR_W-1:0]           clear_addr,
  input  logic signed [SUM_BITS-1:0]  sum,
  input  logic [SCALE_BITS-1:0]       scale,
  input  logic [BCOUNT_BITS-1:0]      bin_count,
  input  logic [REGION_BITS-1:0]      region,
  input  logic [BIN_W-1:0]            read_bin,
  input  logic                        accum_ok,
  output logic [COUNT_BITS-1:0]       rdata
);

  localparam int PROD_BITS = VALUE_BITS + SCALE_BITS;

  logic [VALUE_BITS-1:0] bin_raw;
  logic                  neg;
  logic [ADDR_W-1:0]     addr;
  logic                  hit;
  logic [COUNT_BITS-1:0] mem [DEPTH];

  logic [PROD_BITS-1:0]  prod;
  logic [VALUE_BITS-1:0] bin_eff;
  logic                  bin_ok;
  logic [BIN_W-1:0]      bin_sel;
  logic [ADDR_W-1:0]     addr_next;
  logic [COUNT_BITS-1:0] inc;

  // Scale the shifted value; the bin is the integer part of the Q.32 product
  assign prod = PROD_BITS'(sum[VALUE_BITS-1:0]) * PROD_BITS'(scale);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      bin_raw <= prod[PROD_BITS-1:SCALE_BITS];
      neg     <= sum[SUM_BITS-1];
    end
  end

  // Drop negative sums (unless scale is zero) and bins beyond the range in use
  always_comb begin
    bin_eff = neg ? '0 : bin_raw;
    bin_ok  = (!neg || (scale == '0))
              && (bin_eff < VALUE_BITS'(bin_count))
              && (bin_eff < VALUE_BITS'(MAX_BINS));
    bin_sel = ctrl.use_read_bin ? read_bin : bin_eff[BIN_W-1:0];
    addr_next = ADDR_W'(region) * ADDR_W'(MAX_BINS) + ADDR_W'(bin_sel);
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      addr <= addr_next;
      hit  <= bin_ok && accum_ok;
    end
  end

  // Saturating increment
  assign inc = (rdata == '1) ? rdata : rdata + 1'b1;

  // Counter bank: clear sweep or write back, registered read
  always_ff @(posedge clk) begin
    if (ctrl.clear_en) begin
      mem[clear_addr] <= '0;
    end else if (ctrl.wr_en && hit) begin
      mem[addr] <= inc;
    end
    if (ctrl.rd_en) begin
      rdata <= mem[addr_next];
    end
  end

endmodule

[rtl/regional_triple_histogram.sv]
// Top level of the regional triple histogram: sequencer, three lanes, merge.
//
// After reset the block sweeps all three counter banks to zero, one entry a
// cycle, MAX_BINS*MAX_REGIONS entries (8192 with the defaults); in_stall stays
// high meanwhile, while configuration writes are taken at once. Then each
// transaction runs through its steps from acceptance to the next acceptance:
// capture, multiply by bin_scale, counter read, write back. They are set by the
// single-port counter memory in each lane, which is read and then written for
// every sample. A read transaction whose result finds the output register
// still occupied waits in its last step until the result can be loaded. The
// three values of a sample are binned and counted by three lanes in parallel.
module regional_triple_histogram import rth_pkg::*; #(
  parameter int MAX_BINS    = DEF_MAX_BINS,
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [SCALE_BITS-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [REGION_BITS-1:0]        region,
  input  logic signed [VALUE_BITS-1:0]  value_first,
  input  logic signed [VALUE_BITS-1:0]  value_second,
  input  logic signed [VALUE_BITS-1:0]  value_third,
  input  logic [SEL_BITS-1:0]           hist_select,
  input  logic [RBIN_BITS-1:0]          read_bin,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [OUT_BITS-1:0]           count
);

  localparam int DEPTH  = MAX_BINS * MAX_REGIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BIN_W  = $clog2(MAX_BINS);

  // Configuration registers
  logic [LIMIT_BITS-1:0]  range_limit;
  logic [BCOUNT_BITS-1:0] bin_count;
  logic [SCALE_BITS-1:0]  bin_scale;

  // Sequencer
  rth_state_t        state, state_next;
  logic [ADDR_W-1:0] clear_addr;
  rth_ctrl_t         ctrl;

  // Captured transaction
  logic                        action_q;
  logic [REGION_BITS-1:0]      region_q;
  logic signed [SUM_BITS-1:0]  sum_q [LANES];
  logic [SEL_BITS-1:0]         sel_q;
  logic [BIN_W-1:0]            read_bin_q;
  logic                        accum_ok;
  logic                        read_ok;

  // Input side
  logic                        in_accept;
  logic [VALUE_BITS-1:0]       mag_first;
  logic [VALUE_BITS-1:0]       mag_third;
  logic signed [VALUE_BITS-1:0] vals [LANES];

  // Merge and output
  logic [COUNT_BITS-1:0]       lane_rdata [LANES];
  logic [COUNT_BITS-1:0]       picked;
  logic [OUT_BITS-1:0]         picked_out;
  logic                        out_free;
  logic                        out_load;

  assign vals[0] = value_first;
  assign vals[1] = value_second;
  assign vals[2] = value_third;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit <= RST_RANGE_LIMIT;
      bin_count   <= RST_BIN_COUNT;
      bin_scale   <= RST_BIN_SCALE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RANGE_LIMIT: range_limit <= cfg_data[LIMIT_BITS-1:0];
        REG_BIN_COUNT:   bin_count   <= cfg_data[BCOUNT_BITS-1:0];
        REG_BIN_SCALE:   bin_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the state register and the clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clear_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_MUL;
      ST_MUL:   state_next = ST_READ;
      ST_READ:  state_next = ST_DONE;
      ST_DONE:  if (action_q == ACT_ACCUM || out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall          = 1'b1;
    ctrl.clear_en     = 1'b0;
    ctrl.mul_en       = 1'b0;
    ctrl.rd_en        = 1'b0;
    ctrl.wr_en        = 1'b0;
    ctrl.use_read_bin = (action_q == ACT_READ);
    out_load          = 1'b0;
    case (state)
      ST_CLEAR: ctrl.clear_en = 1'b1;
      ST_IDLE:  in_stall = 1'b0;
      ST_MUL:   ctrl.mul_en = 1'b1;
      ST_READ:  ctrl.rd_en = 1'b1;
      ST_DONE: begin
        ctrl.wr_en = (action_q == ACT_ACCUM);
        out_load   = (action_q == ACT_READ) && out_free;
      end
      default: ;
    endcase
  end

  // Magnitudes for the sample filter
  assign mag_first = value_first[VALUE_BITS-1] ? VALUE_BITS'(-value_first) : value_first;
  assign mag_third = value_third[VALUE_BITS-1] ? VALUE_BITS'(-value_third) : value_third;

  // Capture a transaction, offset each value by the range limit
  always_ff @(posedge clk) begin
    if (in_accept) begin
      action_q   <= action;
      region_q   <= region;
      sel_q      <= hist_select;
      read_bin_q <= BIN_W'(read_bin);
      accum_ok   <= (32'(region) < MAX_REGIONS)
                    && ((mag_first < VALUE_BITS'(range_limit))
                        || (mag_third < VALUE_BITS'(range_limit)));
      read_ok    <= (32'(region) < MAX_REGIONS) && (32'(read_bin) < MAX_BINS)
                    && (hist_select == HIST_FIRST || hist_select == HIST_SECOND
                        || hist_select == HIST_THIRD);
      for (int i = 0; i < LANES; i++) begin
        sum_q[i] <= SUM_BITS'(vals[i]) + $signed({2'b00, range_limit});
      end
    end
  end

  // One lane per value
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rth_lane #(
      .MAX_BINS    (MAX_BINS),
      .MAX_REGIONS (MAX_REGIONS),
      .COUNT_BITS  (COUNT_BITS)
    ) u_lane (
      .clk        (clk),
      .ctrl       (ctrl),
      .clear_addr (clear_addr),
      .sum        (sum_q[g]),
      .scale      (bin_scale),
      .bin_count  (bin_count),
      .region     (region_q),
      .read_bin   (read_bin_q),
      .accum_ok   (accum_ok),
      .rdata      (lane_rdata[g])
    );
  end

  // Merge: pick the requested bank, zero for an invalid read
  always_comb begin
    picked = '0;
    if (read_ok) begin
      case (sel_q)
        HIST_FIRST:  picked = lane_rdata[0];
        HIST_SECOND: picked = lane_rdata[1];
        HIST_THIRD:  picked = lane_rdata[2];
        default:     picked = '0;
      endcase
    end
  end

  // Clamp a wide count to the output field
  if (COUNT_BITS > OUT_BITS) begin : g_clamp
    assign picked_out = (|picked[COUNT_BITS-1:OUT_BITS]) ? '1 : picked[OUT_BITS-1:0];
  end else begin : g_extend
    assign picked_out = OUT_BITS'(picked);
  end

  // Output register: load a read result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      count <= picked_out;
    end
  end

endmodule

[tb/rth_checker.sv]
// Checker for the regional triple histogram: tracks the counter banks and checks every count.
module rth_checker import rth_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [SCALE_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         action,
  input  logic [REGION_BITS-1:0]       region,
  input  logic signed [VALUE_BITS-1:0] value_first,
  input  logic signed [VALUE_BITS-1:0] value_second,
  input  logic signed [VALUE_BITS-1:0] value_third,
  input  logic [SEL_BITS-1:0]          hist_select,
  input  logic [RBIN_BITS-1:0]         read_bin,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [OUT_BITS-1:0]          count,
  output int                           fail_count,
  output int                           reads_pending,
  output int                           counts_checked
);

  localparam int NUM_BINS    = DEF_MAX_BINS;
  localparam int NUM_REGIONS = DEF_MAX_REGIONS;
  localparam int CELLS       = NUM_BINS * NUM_REGIONS;

  // One outstanding read: the count it must return and where it points
  typedef struct {
    logic [OUT_BITS-1:0]    count;
    logic [REGION_BITS-1:0] region;
    logic [SEL_BITS-1:0]    sel;
    logic [RBIN_BITS-1:0]   bin;
  } bin_read_t;

  logic [LIMIT_BITS-1:0]     limit_q;
  logic [BCOUNT_BITS-1:0]    bins_q;
  logic [SCALE_BITS-1:0]     scale_q;
  logic [DEF_COUNT_BITS-1:0] banks [LANES][CELLS];
  bin_read_t                 expected_reads [$];

  initial begin
    fail_count     = 0;
    reads_pending  = 0;
    counts_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("rth_checker: mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic int unsigned magnitude(input logic signed [VALUE_BITS-1:0] v);
    int w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  // Bin a value against the current range and scale; report whether it is kept
  function automatic bit lands_in_bin(input logic signed [VALUE_BITS-1:0] v,
                                      output int unsigned bin);
    logic signed [31:0] sum;
    logic [63:0]        prod;
    int unsigned        used;
    bit                 hit;
    sum  = v;
    sum  = sum + $signed({9'd0, limit_q});
    used = (bins_q < NUM_BINS) ? bins_q : NUM_BINS;
    hit  = 1'b1;
    prod = '0;
    if (sum < 0) begin
      // a zero scale folds even negative sums into bin zero
      if (scale_q != '0) hit = 1'b0;
    end else begin
      prod = ({32'd0, sum} * {32'd0, scale_q}) >> 32;
    end
    if (prod >= used) hit = 1'b0;
    bin = prod[31:0];
    return hit;
  endfunction

  // Count one sample transaction into the three banks
  task automatic count_sample();
    logic signed [VALUE_BITS-1:0] vals [LANES];
    int unsigned                  bin;
    int unsigned                  slot;
    vals[0] = value_first;
    vals[1] = value_second;
    vals[2] = value_third;
    if (region < NUM_REGIONS &&
        (magnitude(value_first) < limit_q || magnitude(value_third) < limit_q)) begin
      for (int lane = 0; lane < LANES; lane++) begin
        if (lands_in_bin(vals[lane], bin)) begin
          slot = region * NUM_BINS + bin;
          // saturate at the top of the counter
          if (banks[lane][slot] != '1) banks[lane][slot] = banks[lane][slot] + 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    bin_read_t   want;
    logic [63:0] stored;
    if (rst) begin
      limit_q = RST_RANGE_LIMIT;
      bins_q  = RST_BIN_COUNT;
      scale_q = RST_BIN_SCALE;
      for (int lane = 0; lane < LANES; lane++)
        for (int slot = 0; slot < CELLS; slot++) banks[lane][slot] = '0;
      expected_reads.delete();
    end else begin
      // compare a returned count with the oldest outstanding read
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          report_mismatch($sformatf("count %0d returned with no read outstanding", count));
        end else begin
          want = expected_reads.pop_front();
          counts_checked++;
          if (count !== want.count)
            report_mismatch($sformatf("region %0d bank %0d bin %0d: count %0d, expected %0d",
                                      want.region, want.sel, want.bin, count, want.count));
        end
      end

      // track register writes; unlisted indexes change nothing
      if (cfg_write) begin
        case (cfg_index)
          REG_RANGE_LIMIT: limit_q = cfg_data[LIMIT_BITS-1:0];
          REG_BIN_COUNT:   bins_q  = cfg_data[BCOUNT_BITS-1:0];
          REG_BIN_SCALE:   scale_q = cfg_data[SCALE_BITS-1:0];
          default: ;
        endcase
      end

      // predict each accepted input transaction
      if (in_valid && !in_stall) begin
        if (action == ACT_ACCUM) begin
          count_sample();
        end else begin
          stored = '0;
          if (region < NUM_REGIONS && read_bin < NUM_BINS &&
              (hist_select == HIST_FIRST || hist_select == HIST_SECOND ||
               hist_select == HIST_THIRD))
            stored = banks[hist_select][region * NUM_BINS + read_bin];
          want.count  = (stored > 64'hFFFF_FFFF) ? '1 : stored[OUT_BITS-1:0];
          want.region = region;
          want.sel    = hist_select;
          want.bin    = read_bin;
          expected_reads.push_back(want);
        end
      end
    end
    reads_pending = expected_reads.size();
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the regional triple histogram: stimulus, idling, register phases, verdict.
module tb_top;
  import rth_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int VALUE_MAX       = 8388607;
  localparam int VALUE_MIN       = -8388608;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNLISTED = 2'd3;
  localparam logic [SEL_BITS-1:0]     HIST_NONE    = 2'd3;

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         cfg_write    = 1'b0;
  logic [CFG_IDX_BITS-1:0]      cfg_index    = REG_RANGE_LIMIT;
  logic [SCALE_BITS-1:0]        cfg_data     = '0;
  logic                         in_valid     = 1'b0;
  logic                         action       = ACT_ACCUM;
  logic [REGION_BITS-1:0]       region       = '0;
  logic signed [VALUE_BITS-1:0] value_first  = '0;
  logic signed [VALUE_BITS-1:0] value_second = '0;
  logic signed [VALUE_BITS-1:0] value_third  = '0;
  logic [SEL_BITS-1:0]          hist_select  = HIST_FIRST;
  logic [RBIN_BITS-1:0]         read_bin     = '0;
  logic                         out_stall    = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic [OUT_BITS-1:0]          count;

  int fail_count;
  int reads_pending;
  int counts_checked;

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_ticket    = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int cur_limit      = RST_RANGE_LIMIT;
  int samples_sent   = 0;
  int reads_sent     = 0;
  int settings_used  = 1;

  regional_triple_histogram DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .region       (region),
    .value_first  (value_first),
    .value_second (value_second),
    .value_third  (value_third),
    .hist_select  (hist_select),
    .read_bin     (read_bin),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .count        (count)
  );

  rth_checker watcher (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .region         (region),
    .value_first    (value_first),
    .value_second   (value_second),
    .value_third    (value_third),
    .hist_select    (hist_select),
    .read_bin       (read_bin),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .count          (count),
    .fail_count     (fail_count),
    .reads_pending  (reads_pending),
    .counts_checked (counts_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive the result stall: random idling, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // End the run if it hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("rth tb: cycle limit reached with %0d reads outstanding", reads_pending);
    $display("tb_top: FAIL");
    $finish;
  end

  // Offer one transaction after a random gap and hold it until accepted
  task automatic offer(input logic act, input logic [REGION_BITS-1:0] rgn,
                       input int v1, input int v2, input int v3,
                       input logic [SEL_BITS-1:0] sel, input logic [RBIN_BITS-1:0] bin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    region       <= rgn;
    value_first  <= v1[VALUE_BITS-1:0];
    value_second <= v2[VALUE_BITS-1:0];
    value_third  <= v3[VALUE_BITS-1:0];
    hist_select  <= sel;
    read_bin     <= bin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (act == ACT_ACCUM) samples_sent++;
    else reads_sent++;
  endtask

  // Drop valid and wait until every read has returned, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (reads_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all three registers, then a write to the unlisted index
  task automatic apply_settings(input logic [LIMIT_BITS-1:0] lim,
                                input logic [BCOUNT_BITS-1:0] bin_total,
                                input logic [SCALE_BITS-1:0] scale);
    cfg_write <= 1'b1;
    cfg_index <= REG_RANGE_LIMIT;
    cfg_data  <= SCALE_BITS'(lim);
    @(negedge clk);
    cfg_index <= REG_BIN_COUNT;
    cfg_data  <= SCALE_BITS'(bin_total);
    @(negedge clk);
    cfg_index <= REG_BIN_SCALE;
    cfg_data  <= scale;
    @(negedge clk);
    cfg_index <= REG_UNLISTED;
    cfg_data  <= $urandom;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_limit = lim;
    settings_used++;
  endtask

  // Scale that spreads bins over [-lim, lim), clamped to the register
  function automatic logic [SCALE_BITS-1:0] scale_for(input int unsigned lim,
                                                      input int unsigned bin_total);
    longint unsigned s;
    if (lim == 0) return '1;
    s = (longint'(bin_total) << 31) / lim;
    return (s > 64'hFFFF_FFFF) ? '1 : s[SCALE_BITS-1:0];
  endfunction

  // Mostly near and around the range, sometimes anywhere in the field
  function automatic int pick_value(input int lim);
    int span;
    int v;
    span = lim + lim / 16 + 1;
    case ($urandom_range(0, 9))
      0:       v = int'($urandom_range(0, 16777215)) + VALUE_MIN;
      1:       v = lim - 1 + int'($urandom_range(0, 2));
      2:       v = -lim - 1 + int'($urandom_range(0, 2));
      default: v = int'($urandom_range(0, 2 * span)) - span;
    endcase
    if (v > VALUE_MAX) v = VALUE_MAX;
    if (v < VALUE_MIN) v = VALUE_MIN;
    return v;
  endfunction

  // Concentrate on two regions so reads find populated bins
  function automatic logic [REGION_BITS-1:0] pick_region();
    if ($urandom_range(0, 4) == 0) return REGION_BITS'($urandom_range(0, 63));
    return REGION_BITS'($urandom_range(0, 1));
  endfunction

  task automatic random_item();
    logic                 act;
    logic [SEL_BITS-1:0]  sel;
    act = ($urandom_range(0, 9) < 6) ? ACT_ACCUM : ACT_READ;
    sel = ($urandom_range(0, 9) == 0) ? HIST_NONE : SEL_BITS'($urandom_range(0, 2));
    offer(act, pick_region(), pick_value(cur_limit), pick_value(cur_limit),
          pick_value(cur_limit), sel, RBIN_BITS'($urandom_range(0, 127)));
  endtask

  // Directed transactions at the reset settings: 128 bins over [-65536, 65536)
  task automatic directed_items();
    offer(ACT_ACCUM, 0, 0, 0, 0, HIST_FIRST, 0);            // middle bin in every bank
    offer(ACT_ACCUM, 0, -65536, -65536, 0, HIST_FIRST, 0);  // first on the limit, third passes
    offer(ACT_ACCUM, 0, 65535, 65535, 65535, HIST_FIRST, 0); // top bin
    offer(ACT_ACCUM, 0, 0, 65536, 0, HIST_FIRST, 0);        // second one bin too high
    offer(ACT_ACCUM, 0, 0, -65537, 0, HIST_FIRST, 0);       // second has a negative sum
    offer(ACT_ACCUM, 1, 0, VALUE_MIN, VALUE_MAX, HIST_FIRST, 0);
    offer(ACT_ACCUM, 1, 65536, 0, -65536, HIST_FIRST, 0);   // filtered out
    offer(ACT_ACCUM, 1, 100, 100, VALUE_MAX, HIST_FIRST, 0); // first alone passes
    offer(ACT_ACCUM, 1, VALUE_MIN, 5, 5, HIST_FIRST, 0);    // third alone passes
    offer(ACT_ACCUM, 63, -1, -1, -1, HIST_FIRST, 0);        // top region
    // same bin back to back
    repeat (3) offer(ACT_ACCUM, 0, 0, 0, 0, HIST_FIRST, 0);
    offer(ACT_READ, 0, 0, 0, 0, HIST_FIRST, 64);
    offer(ACT_READ, 0, 0, 0, 0, HIST_SECOND, 64);
    offer(ACT_READ, 0, 0, 0, 0, HIST_THIRD, 64);
    offer(ACT_READ, 0, 0, 0, 0, HIST_NONE, 64);
    offer(ACT_READ, 0, VALUE_MAX, VALUE_MIN, -1, HIST_FIRST, 0);
    offer(ACT_READ, 0, 0, 0, 0, HIST_SECOND, 127);
    offer(ACT_READ, 0, 0, 0, 0, HIST_THIRD, 127);
    offer(ACT_READ, 63, 0, 0, 0, HIST_FIRST, 63);
    offer(ACT_READ, 1, 0, 0, 0, HIST_THIRD, 64);
    offer(ACT_READ, 63, 0, 0, 0, HIST_SECOND, 127);
    // read straight after a write to the same bin
    offer(ACT_ACCUM, 2, 0, 0, 0, HIST_FIRST, 0);
    offer(ACT_READ, 2, 0, 0, 0, HIST_SECOND, 64);
  endtask

  initial begin : stimulus
    logic [LIMIT_BITS-1:0]  lim;
    logic [BCOUNT_BITS-1:0] bin_total;
    logic [SCALE_BITS-1:0]  scale;
    int                     mode;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      // receiver idles heavily first, then the sender does, then neither
      mode = phase * 3 / PHASES;
      send_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 88 : 0;
      recv_idle_pct = (mode == 0) ? 88 : (mode == 1) ? 15 : 0;

      if (phase == 0) begin
        directed_items();
      end else begin
        wait_drained();
        lim       = 23'(($urandom_range(1, VALUE_MAX) >> $urandom_range(0, 20)) | 1);
        bin_total = BCOUNT_BITS'($urandom_range(1, 128));
        case (phase)
          1: begin lim = 23'h7F_FFFF; bin_total = 8'd128; end
          2: begin lim = 23'd1;       bin_total = 8'd1;   end
          4: begin lim = 23'd0;       bin_total = 8'd64;  end
          6: begin lim = 23'd65536;   bin_total = 8'd255; end
          7: begin                    bin_total = 8'd0;   end
          8: begin lim = 23'd65536;   bin_total = 8'd128; end
          9: begin lim = 23'd4096;    bin_total = 8'd128; end
          default: ;
        endcase
        scale = scale_for(lim, (bin_total == 0 || bin_total > 128) ? 128 : bin_total);
        case (phase)
          2: scale = '1;
          4: scale = 32'd1 << 20;
          5: scale = '0;
          6: scale = 32'd8388608;
          8: scale = 32'd1;
          9: scale = '1;
          default: ;
        endcase
        apply_settings(lim, bin_total, scale);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off while items keep coming
        if (phase == 8 && n == 30) hold_ticket++;
        // pause the sender until every read has returned
        if (phase == 10 && n == 50) wait_drained();
        random_item();
      end
    end

    wait_drained();
    $display("rth tb: %0d transactions (%0d samples, %0d reads), %0d counts compared",
             samples_sent + reads_sent, samples_sent, reads_sent, counts_checked);
    $display("rth tb: %0d register settings incl. zero range, zero scale, zero/oversized bins",
             settings_used);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
